// ===== rtl/core/cdd_pkg.sv =====
// Shared types and constants of the collinear direction detector.
`timescale 1ns / 1ps
package cdd_pkg;

   localparam int TableDepth = 8192;
   localparam int SlotBits   = $clog2(TableDepth);
   localparam int GenBits    = 16;
   localparam int KeyBits    = 50;
   localparam int OwnerBits  = 24;
   localparam int CoordBits  = 32;
   localparam int MagBits    = CoordBits + 1;
   localparam int ShiftBits  = $clog2(MagBits + 1);
   localparam int XyBits     = 13;
   localparam int ZBits      = 24;

   localparam logic [63:0] HashAdd  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] HashMul1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] HashMul2 = 64'h94d049bb133111eb;

   localparam logic [MagBits-1:0] XyBias = MagBits'(1 << 12);
   localparam logic [MagBits-1:0] ZBias  = MagBits'(1 << 23);

   // Result codes.
   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_COLL     = 3'd1,
      ST_REPEAT   = 3'd2,
      ST_BOUND    = 3'd3,
      ST_FULL     = 3'd4,
      ST_APEX     = 3'd5,
      ST_NO_APEX  = 3'd6
   } status_type;

   // What the back end has to do with a queued job.
   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_APEX   = 2'd1,
      OP_PROBE  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                 op;
      status_type             status;
      logic [KeyBits-1:0]     key;
      logic [OwnerBits-1:0]   owner;
   } job_type;

   typedef struct packed {
      logic [GenBits-1:0]     gen;
      logic [KeyBits-1:0]     key;
      logic [OwnerBits-1:0]   owner;
   } slot_type;

endpackage

// ===== rtl/core/cdd_front.sv =====
// Front end: apex latch, gcd reduction, exact division and key packing.
`timescale 1ns / 1ps
module cdd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  logic                           req_kind,
   input  logic signed [31:0]             req_point_x,
   input  logic signed [31:0]             req_point_y,
   input  logic signed [31:0]             req_point_z,
   input  logic [23:0]                    req_point_index,
   input  logic                           queue_full,
   output logic                           idle,
   output logic                           push,
   output cdd_pkg::job_type               push_job
);
   import cdd_pkg::*;

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_GCD1 = 6'b000010,
      F_GCD2 = 6'b000100,
      F_DIV  = 6'b001000,
      F_FIN  = 6'b010000,
      F_PUSH = 6'b100000
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [CoordBits-1:0] apex_x_ff, apex_y_ff, apex_z_ff;
   logic [CoordBits-1:0] apex_x_in, apex_y_in, apex_z_in;
   logic apex_valid_ff, apex_valid_in;
   logic [MagBits-1:0] mag_ff [3];
   logic [MagBits-1:0] mag_in [3];
   logic [2:0] neg_ff, neg_in;
   logic [MagBits-1:0] ga_ff, ga_in, gb_ff, gb_in, g_ff, g_in;
   logic [ShiftBits-1:0] k_ff, k_in, bit_ff, bit_in;
   logic [1:0] comp_ff, comp_in;
   logic [MagBits-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic [OwnerBits-1:0] owner_ff, owner_in;
   job_type job_ff, job_in;

   logic [MagBits-1:0] dx, dy, dz;
   logic gcd_done;
   logic [MagBits-1:0] gcd_res;
   logic [MagBits:0] trial;
   logic [MagBits:0] trial_sub;
   logic flip;
   logic [2:0] sn;
   logic in_bound;
   logic [XyBits:0] fx, fy;
   logic [ZBits:0] fz;

   // Differences from the apex, one bit wider than the coordinates.
   assign dx = {req_point_x[31], req_point_x} - {apex_x_ff[31], apex_x_ff};
   assign dy = {req_point_y[31], req_point_y} - {apex_y_ff[31], apex_y_ff};
   assign dz = {req_point_z[31], req_point_z} - {apex_z_ff[31], apex_z_ff};

   // Binary gcd: finished once either operand is zero.
   assign gcd_done = (ga_ff == '0) || (gb_ff == '0);
   assign gcd_res  = ((ga_ff == '0) ? gb_ff : ga_ff) << k_ff;

   // Restoring division, one quotient bit a cycle.
   assign trial     = {rem_ff, dvd_ff[MagBits-1]};
   assign trial_sub = trial - {1'b0, g_ff};

   // Canonical sign: first nonzero component made positive.
   always_comb begin
      if (mag_ff[0] != '0) begin
         flip = neg_ff[0];
      end else if (mag_ff[1] != '0) begin
         flip = neg_ff[1];
      end else begin
         flip = neg_ff[2];
      end
      sn = neg_ff ^ {3{flip}};
      in_bound = (sn[0] ? (mag_ff[0] <= XyBias) : (mag_ff[0] < XyBias)) &&
                 (sn[1] ? (mag_ff[1] <= XyBias) : (mag_ff[1] < XyBias)) &&
                 (sn[2] ? (mag_ff[2] <= ZBias) : (mag_ff[2] < ZBias));
      fx = sn[0] ? (XyBias[XyBits:0] - mag_ff[0][XyBits:0])
                 : (XyBias[XyBits:0] + mag_ff[0][XyBits:0]);
      fy = sn[1] ? (XyBias[XyBits:0] - mag_ff[1][XyBits:0])
                 : (XyBias[XyBits:0] + mag_ff[1][XyBits:0]);
      fz = sn[2] ? (ZBias[ZBits:0] - mag_ff[2][ZBits:0])
                 : (ZBias[ZBits:0] + mag_ff[2][ZBits:0]);
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      apex_x_in     = apex_x_ff;
      apex_y_in     = apex_y_ff;
      apex_z_in     = apex_z_ff;
      apex_valid_in = apex_valid_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      ga_in         = ga_ff;
      gb_in         = gb_ff;
      g_in          = g_ff;
      k_in          = k_ff;
      bit_in        = bit_ff;
      comp_in       = comp_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      owner_in      = owner_ff;
      job_in        = job_ff;
      unique case (state_ff) inside
         F_IDLE: begin
            if (take) begin
               job_in.key   = '0;
               job_in.owner = '0;
               if (!req_kind) begin
                  apex_x_in     = req_point_x;
                  apex_y_in     = req_point_y;
                  apex_z_in     = req_point_z;
                  apex_valid_in = 1'b1;
                  job_in.op     = OP_APEX;
                  job_in.status = ST_APEX;
                  state_in      = F_PUSH;
               end else if (!apex_valid_ff) begin
                  job_in.op     = OP_REPORT;
                  job_in.status = ST_NO_APEX;
                  state_in      = F_PUSH;
               end else begin
                  neg_in    = {dz[MagBits-1], dy[MagBits-1], dx[MagBits-1]};
                  mag_in[0] = dx[MagBits-1] ? -dx : dx;
                  mag_in[1] = dy[MagBits-1] ? -dy : dy;
                  mag_in[2] = dz[MagBits-1] ? -dz : dz;
                  ga_in     = mag_in[0];
                  gb_in     = mag_in[1];
                  k_in      = '0;
                  owner_in  = req_point_index;
                  state_in  = F_GCD1;
               end
            end
         end
         F_GCD1, F_GCD2: begin
            if (gcd_done) begin
               if (state_ff == F_GCD1) begin
                  ga_in    = gcd_res;
                  gb_in    = mag_ff[2];
                  k_in     = '0;
                  state_in = F_GCD2;
               end else if (gcd_res == '0) begin
                  job_in.op     = OP_REPORT;
                  job_in.status = ST_REPEAT;
                  state_in      = F_PUSH;
               end else begin
                  g_in     = gcd_res;
                  comp_in  = 2'd0;
                  dvd_in   = mag_ff[0];
                  rem_in   = '0;
                  bit_in   = '0;
                  state_in = F_DIV;
               end
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         F_DIV: begin
            if (trial_sub[MagBits]) begin
               rem_in = trial[MagBits-1:0];
               dvd_in = {dvd_ff[MagBits-2:0], 1'b0};
            end else begin
               rem_in = trial_sub[MagBits-1:0];
               dvd_in = {dvd_ff[MagBits-2:0], 1'b1};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == ShiftBits'(MagBits - 1)) begin
               mag_in[comp_ff] = dvd_in;
               bit_in          = '0;
               rem_in          = '0;
               if (comp_ff == 2'd2) begin
                  state_in = F_FIN;
               end else begin
                  comp_in = comp_ff + 1'b1;
                  dvd_in  = mag_ff[comp_ff + 1'b1];
               end
            end
         end
         F_FIN: begin
            if (in_bound) begin
               job_in.op     = OP_PROBE;
               job_in.status = ST_NEW;
               job_in.key    = {fx[XyBits-1:0], fy[XyBits-1:0], fz[ZBits-1:0]};
               job_in.owner  = owner_ff;
            end else begin
               job_in.op     = OP_REPORT;
               job_in.status = ST_BOUND;
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         apex_valid_ff <= 1'b0;
         apex_x_ff     <= '0;
         apex_y_ff     <= '0;
         apex_z_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         apex_valid_ff <= apex_valid_in;
         apex_x_ff     <= apex_x_in;
         apex_y_ff     <= apex_y_in;
         apex_z_ff     <= apex_z_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      ga_ff    <= ga_in;
      gb_ff    <= gb_in;
      g_ff     <= g_in;
      k_ff     <= k_in;
      bit_ff   <= bit_in;
      comp_ff  <= comp_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      owner_ff <= owner_in;
      job_ff   <= job_in;
   end

   assign idle     = (state_ff == F_IDLE);
   assign push     = (state_ff == F_PUSH) && !queue_full;
   assign push_job = job_ff;

endmodule

// ===== rtl/core/cdd_queue.sv =====
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
module cdd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cdd_pkg::job_type    push_job,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output cdd_pkg::job_type    head
);
   import cdd_pkg::*;

   job_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   // A full queue is never written, an empty one never read.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue read while empty");

endmodule

// ===== rtl/core/cdd_back.sv =====
// Back end: generation control, splitmix hashing and linear-probe table walk.
`timescale 1ns / 1ps
module cdd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  cdd_pkg::job_type       head,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_status,
   output logic [23:0]            rsp_prior_index,
   output logic [49:0]            rsp_direction_code
);
   import cdd_pkg::*;

   typedef enum logic [6:0] {
      B_CLEAR = 7'b0000001,
      B_IDLE  = 7'b0000010,
      B_HINIT = 7'b0000100,
      B_MUL   = 7'b0001000,
      B_MIX   = 7'b0010000,
      B_RD    = 7'b0100000,
      B_CMP   = 7'b1000000
   } bstate_type;

   slot_type table_mem [TableDepth];

   bstate_type state_ff, state_in;
   logic [GenBits-1:0] gen_ff, gen_in;
   logic [SlotBits-1:0] clr_ff, clr_in, slot_ff, slot_in, n_ff, n_in;
   logic [KeyBits-1:0] key_ff, key_in;
   logic [OwnerBits-1:0] owner_ff, owner_in;
   logic [63:0] m_ff, m_in, acc_ff, acc_in, prod_ff, prod_in;
   logic [1:0] cnt_ff, cnt_in;
   logic round_ff, round_in;
   slot_type rd_ff;
   logic strobe_ff, strobe_in;
   status_type status_ff, status_in;
   logic [OwnerBits-1:0] prior_ff, prior_in;
   logic [KeyBits-1:0] code_ff, code_in;

   logic we;
   logic [SlotBits-1:0] wa;
   slot_type wd;
   logic [63:0] hinit, mul_c, fin;
   logic [31:0] mul_a, mul_b;
   logic [GenBits-1:0] gen_next;

   assign hinit    = {{(64 - KeyBits){1'b0}}, head.key} + HashAdd;
   assign mul_c    = round_ff ? HashMul2 : HashMul1;
   assign mul_a    = (cnt_ff == 2'd2) ? m_ff[63:32] : m_ff[31:0];
   assign mul_b    = (cnt_ff == 2'd1) ? mul_c[63:32] : mul_c[31:0];
   assign fin      = acc_ff ^ (acc_ff >> 31);
   assign gen_next = gen_ff + 1'b1;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      gen_in    = gen_ff;
      clr_in    = clr_ff;
      slot_in   = slot_ff;
      n_in      = n_ff;
      key_in    = key_ff;
      owner_in  = owner_ff;
      m_in      = m_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      round_in  = round_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      prior_in  = prior_ff;
      code_in   = code_ff;
      we        = 1'b0;
      wa        = slot_ff;
      wd        = '{gen: gen_ff, key: key_ff, owner: owner_ff};
      pop       = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            we     = 1'b1;
            wa     = clr_ff;
            wd     = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SlotBits'(TableDepth - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               case (head.op)
                  OP_APEX: begin
                     strobe_in = 1'b1;
                     status_in = ST_APEX;
                     prior_in  = '0;
                     code_in   = '0;
                     if (gen_next == '0) begin
                        gen_in   = GenBits'(1);
                        clr_in   = '0;
                        state_in = B_CLEAR;
                     end else begin
                        gen_in = gen_next;
                     end
                  end
                  OP_PROBE: begin
                     key_in   = head.key;
                     owner_in = head.owner;
                     m_in     = hinit ^ (hinit >> 30);
                     round_in = 1'b0;
                     cnt_in   = '0;
                     state_in = B_MUL;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = head.status;
                     prior_in  = '0;
                     code_in   = '0;
                  end
               endcase
            end
         end
         B_HINIT: begin
            state_in = B_MUL;
         end
         B_MUL: begin
            // Low 64 bits of m * c from three 32-bit partial products.
            prod_in = mul_a * mul_b;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 2'd1) begin
               acc_in = prod_ff;
            end else if (cnt_ff != 2'd0) begin
               acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            end
            if (cnt_ff == 2'd3) begin
               cnt_in   = '0;
               state_in = B_MIX;
            end
         end
         B_MIX: begin
            if (!round_ff) begin
               m_in     = acc_ff ^ (acc_ff >> 27);
               round_in = 1'b1;
               state_in = B_MUL;
            end else begin
               slot_in  = fin[SlotBits-1:0];
               n_in     = '0;
               state_in = B_RD;
            end
         end
         B_RD: begin
            state_in = B_CMP;
         end
         B_CMP: begin
            if (rd_ff.gen != gen_ff) begin
               we        = 1'b1;
               strobe_in = 1'b1;
               status_in = ST_NEW;
               prior_in  = '0;
               code_in   = key_ff;
               state_in  = B_IDLE;
            end else if (rd_ff.key == key_ff) begin
               strobe_in = 1'b1;
               status_in = ST_COLL;
               prior_in  = rd_ff.owner;
               code_in   = key_ff;
               state_in  = B_IDLE;
            end else if (n_ff == SlotBits'(TableDepth - 1)) begin
               strobe_in = 1'b1;
               status_in = ST_FULL;
               prior_in  = '0;
               code_in   = key_ff;
               state_in  = B_IDLE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               n_in     = n_ff + 1'b1;
               state_in = B_RD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Slot table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[wa] <= wd;
      end
      rd_ff <= table_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_CLEAR;
         gen_ff    <= '0;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         gen_ff    <= gen_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
      end
      slot_ff   <= slot_in;
      n_ff      <= n_in;
      key_ff    <= key_in;
      owner_ff  <= owner_in;
      m_ff      <= m_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      cnt_ff    <= cnt_in;
      round_ff  <= round_in;
      status_ff <= status_in;
      prior_ff  <= prior_in;
      code_ff   <= code_in;
   end

   assign clearing           = (state_ff == B_CLEAR);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_prior_index    = prior_ff;
   assign rsp_direction_code = code_ff;

   // A beat leaves only from the dispatch or compare step.
   a_beat_origin: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == B_IDLE || $past(state_ff) == B_CMP))
      else $error("result beat from unexpected state");
   // The generation in use is never the cleared value once an apex is taken.
   a_gen_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CMP) |-> (gen_ff != '0))
      else $error("table walk with generation zero");
   // Owner is reported only for a collinear match.
   a_prior_only_coll: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && status_ff != ST_COLL) |-> (prior_ff == '0))
      else $error("owner reported without a match");

endmodule

// ===== rtl/core/collinear_direction_detector.sv =====
// Top level of the collinear direction detector.
`timescale 1ns / 1ps
// Apex beats and early reports pass through the front end's push state and the job queue
// to a registered rsp_strobe. Probe beats pass through binary gcd, bit-serial division,
// bounding and hand-over, dispatch and hashing on one 32x32 multiplier, and a read and
// compare per table slot visited; busy is high while the front end works.
// After reset, and after a generation wrap, a clearing pass runs over the whole
// slot table with busy high. Results cannot be stalled by the receiver.
module collinear_direction_detector (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   input  logic [23:0]         req_point_index,
   output logic                rsp_strobe,
   output logic [2:0]          rsp_status,
   output logic [23:0]         rsp_prior_index,
   output logic [49:0]         rsp_direction_code
);
   import cdd_pkg::*;

   logic front_idle, clearing, take;
   logic push, pop, full, empty;
   job_type push_job, head;

   assign busy = !front_idle || clearing;
   assign take = start && !busy;

   cdd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .req_kind        (req_kind),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_point_index (req_point_index),
      .queue_full      (full),
      .idle            (front_idle),
      .push            (push),
      .push_job        (push_job)
   );

   cdd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   cdd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (empty),
      .head               (head),
      .pop                (pop),
      .clearing           (clearing),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_prior_index    (rsp_prior_index),
      .rsp_direction_code (rsp_direction_code)
   );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the collinear direction detector.
`timescale 1ns / 1ps
module testbench;
   import cdd_pkg::*;

   localparam longint CycleLimit = 4000000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_kind;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic signed [31:0] req_point_z;
   logic [23:0]        req_point_index;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic [23:0]        rsp_prior_index;
   logic [49:0]        rsp_direction_code;

   collinear_direction_detector u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_z        (req_point_z),
      .req_point_index    (req_point_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_prior_index    (rsp_prior_index),
      .rsp_direction_code (rsp_direction_code)
   );

   typedef struct packed {
      status_type         status;
      logic [23:0]        prior;
      logic [KeyBits-1:0] code;
   } verdict_type;

   // Our own copy of the detector state.
   logic signed [31:0]   apex_x, apex_y, apex_z;
   bit                   apex_known;
   bit [GenBits-1:0]     gen_now;
   bit [GenBits-1:0]     slot_gen [TableDepth];
   bit [KeyBits-1:0]     slot_key [TableDepth];
   bit [OwnerBits-1:0]   slot_owner [TableDepth];

   verdict_type verdict_q[$];
   int          mismatches;
   bit          idling_on;
   longint      cycle_count;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic bit [63:0] mix64(bit [63:0] h);
      h = h + HashAdd;
      h = (h ^ (h >> 30)) * HashMul1;
      h = (h ^ (h >> 27)) * HashMul2;
      return h ^ (h >> 31);
   endfunction

   // Works out the result of one beat and updates the state copy.
   function automatic verdict_type detect_direction(bit kind, logic signed [31:0] px,
         logic signed [31:0] py, logic signed [31:0] pz, logic [23:0] idx);
      verdict_type     v;
      longint          dx, dy, dz;
      longint unsigned g;
      bit [KeyBits-1:0] key;
      bit [SlotBits-1:0] slot;
      v = '{status: ST_NEW, prior: '0, code: '0};
      if (!kind) begin
         apex_x = px;
         apex_y = py;
         apex_z = pz;
         apex_known = 1'b1;
         gen_now = gen_now + 1'b1;
         if (gen_now == 0) begin
            foreach (slot_gen[i]) slot_gen[i] = '0;
            gen_now = GenBits'(1);
         end
         v.status = ST_APEX;
         return v;
      end
      if (!apex_known) begin
         v.status = ST_NO_APEX;
         return v;
      end
      dx = longint'(px) - longint'(apex_x);
      dy = longint'(py) - longint'(apex_y);
      dz = longint'(pz) - longint'(apex_z);
      g = gcd_of(gcd_of(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy), dz < 0 ? -dz : dz);
      if (g == 0) begin
         v.status = ST_REPEAT;
         return v;
      end
      dx = dx / longint'(g);
      dy = dy / longint'(g);
      dz = dz / longint'(g);
      // Canonical sign: the first nonzero component is positive.
      if (dx < 0 || (dx == 0 && (dy < 0 || (dy == 0 && dz < 0)))) begin
         dx = -dx;
         dy = -dy;
         dz = -dz;
      end
      if (dx < -4096 || dx >= 4096 || dy < -4096 || dy >= 4096 ||
          dz < -(longint'(1) << 23) || dz >= (longint'(1) << 23)) begin
         v.status = ST_BOUND;
         return v;
      end
      key = KeyBits'(((dx + 4096) << 37) | ((dy + 4096) << 24) | (dz + (longint'(1) << 23)));
      v.code = key;
      slot = SlotBits'(mix64(64'(key)));
      // Linear probe walk.
      for (int n = 0; n < TableDepth; n++) begin
         if (slot_gen[slot] != gen_now) begin
            slot_gen[slot] = gen_now;
            slot_key[slot] = key;
            slot_owner[slot] = idx;
            v.status = ST_NEW;
            return v;
         end
         if (slot_key[slot] == key) begin
            v.status = ST_COLL;
            v.prior = slot_owner[slot];
            return v;
         end
         slot = slot + 1'b1;
      end
      v.status = ST_FULL;
      return v;
   endfunction

   // Result checker: every strobed beat is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: status %0d", rsp_status);
         end else begin
            verdict_type w;
            w = verdict_q.pop_front();
            if (rsp_status !== w.status || rsp_prior_index !== w.prior ||
                rsp_direction_code !== w.code) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d prior %0d code %h, got %0d %0d %h",
                     w.status, w.prior, w.code, rsp_status, rsp_prior_index,
                     rsp_direction_code);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_in(longint lo, longint hi);
      return 32'(lo + longint'($urandom_range(32'(hi - lo))));
   endfunction

   // Sends one beat and records its predicted result once accepted.
   task automatic send_beat(bit kind, logic signed [31:0] px, logic signed [31:0] py,
         logic signed [31:0] pz, logic [23:0] idx);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(99) < 17) gap = $urandom_range(8, 1);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      req_point_index <= idx;
      do @(posedge clock); while (busy);
      verdict_q.insert(verdict_q.size(), detect_direction(kind, px, py, pz, idx));
   endtask

   // Holds off the sender until every result is in.
   task automatic drain_results();
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Probes before any apex, extremes of the coordinates and boundary directions.
   task automatic test_directed();
      send_beat(1'b1, 5, 6, 7, 24'hFFFFFF);
      send_beat(1'b0, 0, 0, 0, 0);
      send_beat(1'b1, 1, 2, 3, 24'h000001);
      send_beat(1'b1, 2, 4, 6, 24'h000002);
      send_beat(1'b1, -3, -6, -9, 24'h000003);
      send_beat(1'b1, 0, 0, 0, 24'h000004);
      send_beat(1'b1, 4095, -4096, -(1 << 23), 24'hABCDEF);
      send_beat(1'b1, 4096, 1, 1, 24'h5);
      send_beat(1'b1, 1, 4096, 1, 24'h6);
      send_beat(1'b1, 1, 1, 1 << 23, 24'h7);
      send_beat(1'b1, 0, 0, -5, 24'h8);
      send_beat(1'b1, 0, 0, 9, 24'h9);
      send_beat(1'b1, 0, -7, 0, 24'hA);
      send_beat(1'b1, 0, 3, 0, 24'hB);
      drain_results();
      send_beat(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 24'h123456);
      send_beat(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'h654321);
      send_beat(1'b1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 24'hC);
      send_beat(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hD);
      send_beat(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'h0);
      send_beat(1'b1, 32'sh7FFFFFFE, 32'sh7FFFFFFD, 32'sh7FFFFFFC, 24'hE);
      send_beat(1'b1, 32'sh7FFFFFFD, 32'sh7FFFFFFB, 32'sh7FFFFFF9, 24'hF);
      drain_results();
   endtask

   // Rounds of points along eight directions through a random apex, mixed with random points and the apex.
   task automatic test_direction_families(int rounds, int per_round);
      longint dir_x[8], dir_y[8], dir_z[8];
      longint k, qx, qy, qz;
      logic signed [31:0] ax, ay, az;
      int d;
      for (int r = 0; r < rounds; r++) begin
         idling_on = (r != 3);
         ax = rand_in(-(longint'(1) << 30), longint'(1) << 30);
         ay = rand_in(-(longint'(1) << 30), longint'(1) << 30);
         az = rand_in(-(longint'(1) << 30), longint'(1) << 30);
         send_beat(1'b0, ax, ay, az, 24'($urandom));
         foreach (dir_x[i]) begin
            dir_x[i] = $urandom_range(4096);
            dir_y[i] = longint'($urandom_range(8191)) - 4096;
            dir_z[i] = $urandom_range(1) ? longint'($urandom_range(63)) - 32 :
               longint'($urandom_range(32'h00FFFFFF)) - (longint'(1) << 23);
         end
         for (int n = 0; n < per_round; n++) begin
            case ($urandom_range(9))
               0: send_beat(1'b1, 32'($urandom), 32'($urandom), 32'($urandom),
                     24'($urandom));
               1: send_beat(1'b1, ax, ay, az, 24'($urandom));
               default: begin
                  d = $urandom_range(7);
                  k = longint'($urandom_range(400)) - 200;
                  if (k == 0) k = 1;
                  qx = ax + k * dir_x[d];
                  qy = ay + k * dir_y[d];
                  qz = az + k * dir_z[d];
                  if (qz > 32'sh7FFFFFFF || qz < -(longint'(1) << 31) ||
                      qx > 32'sh7FFFFFFF || qy > 32'sh7FFFFFFF || qy < -(longint'(1) << 31)) begin
                     qx = ax + dir_x[d];
                     qy = ay + dir_y[d];
                     qz = az + dir_z[d];
                  end
                  send_beat(1'b1, 32'(qx), 32'(qy), 32'(qz), 24'($urandom));
               end
            endcase
         end
         if (r % 5 == 4) drain_results();
      end
      idling_on = 1'b1;
   endtask

   // Runs the generation counter round so the table must be cleared.
   task automatic test_generation_wrap();
      idling_on = 1'b0;
      while (gen_now != {GenBits{1'b1}})
         send_beat(1'b0, 0, 0, 0, 0);
      send_beat(1'b1, 1, 2, 3, 24'h111);
      send_beat(1'b1, 5, 5, 5, 24'h222);
      send_beat(1'b0, 0, 0, 0, 0);
      send_beat(1'b1, 1, 2, 3, 24'h333);
      send_beat(1'b1, 2, 4, 6, 24'h444);
      send_beat(1'b1, 0, 0, -5, 24'h555);
      idling_on = 1'b1;
      drain_results();
   endtask

   initial begin
      apex_known = 1'b0;
      gen_now = '0;
      foreach (slot_gen[i]) slot_gen[i] = '0;
      mismatches = 0;
      cycle_count = 0;
      idling_on = 1'b1;
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      req_point_index <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_direction_families(20, 80);
      test_generation_wrap();
      test_direction_families(2, 60);

      drain_results();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
